@@ rtl/trct_pkg.sv @@
// Package: shared constants, payload types and control structs for the texture cache table
`timescale 1ns / 1ps
package trct_pkg;

    localparam int ENTRIES       = 64;
    localparam int IDX_W         = $clog2(ENTRIES);
    localparam int CNT_W         = IDX_W + 1;
    localparam int SECTION_BITS  = 15;              // 32K sections
    localparam int MAX_SECTIONS  = 128;
    localparam int BACK_SECTIONS = 4;
    localparam int STAMP_W       = 32;
    localparam int SECT_W        = 24 - SECTION_BITS; // section of a start address
    localparam int ESECT_W       = 25 - SECTION_BITS; // section of an end address

    // Request codes
    typedef enum logic [1:0] {
        REQ_FIND  = 2'd0,
        REQ_ADD   = 2'd1,
        REQ_WIPE  = 2'd2,
        REQ_CLEAR = 2'd3
    } t_req_code;

    // Result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_BAD_SECT  = 3'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [23:0] start_address;
        logic [24:0] end_address;
        logic [3:0]  large_lod;
        logic [2:0]  aspect_code;
        logic [3:0]  texel_format;
        logic [31:0] content_hash;
        logic        palette_mode;
        logic        want_second;
    } t_req;

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] tex_name;
        logic [7:0] tex2_name;
        logic       palette_changed;
    } t_rsp;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic update;
        logic respond;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic need_scan;
        logic scan_done;
        logic out_free;
    } t_stat;

endpackage

@@ rtl/trct_ctrl.sv @@
// Controller: sequences load, table scan, update and response of one request
`timescale 1ns / 1ps
module trct_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  trct_pkg::t_stat i_stat,
    output trct_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_UPDATE = 4'b0100,
        S_RESP   = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_req_ready = (r_state == S_IDLE);
    assign accept      = i_req_valid && o_req_ready;

    // Commands
    always_comb begin
        o_cmd         = '0;
        o_cmd.load    = accept;
        o_cmd.scan    = (r_state == S_SCAN);
        o_cmd.update  = (r_state == S_UPDATE);
        o_cmd.respond = (r_state == S_RESP) && i_stat.out_free;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = i_stat.need_scan ? S_SCAN : S_UPDATE;
            end
            S_SCAN: begin
                if (i_stat.scan_done) n_state = S_UPDATE;
            end
            S_UPDATE: n_state = S_RESP;
            S_RESP: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

endmodule

@@ rtl/trct_dpath.sv @@
// Datapath: entry memories, valid bits, scan compare, update logic and result register
`timescale 1ns / 1ps
module trct_dpath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  trct_pkg::t_req  i_req,
    input  logic [7:0]      i_cfg_data,
    input  logic            i_cfg_we,
    input  trct_pkg::t_cmd  i_cmd,
    output trct_pkg::t_stat o_stat,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    output trct_pkg::t_rsp  o_rsp
);

    typedef struct packed {
        logic [23:0]                  start_a;
        logic [24:0]                  end_a;
        logic [10:0]                  key;
        logic                         second;
        logic [trct_pkg::STAMP_W-1:0] stamp;
    } t_entry;

    t_entry                        r_mem [trct_pkg::ENTRIES];
    logic [31:0]                   r_hash_mem [trct_pkg::ENTRIES];
    t_entry                        r_ent_q;
    logic [31:0]                   r_hash_q;
    logic [trct_pkg::ENTRIES-1:0]  r_valid;
    logic [7:0]                    r_cfg;
    trct_pkg::t_req                r_req;
    logic [trct_pkg::CNT_W-1:0]    r_cnt;
    logic                          r_rd_vld;
    logic [trct_pkg::IDX_W-1:0]    r_rd_idx;
    logic                          r_best_found;
    logic [trct_pkg::IDX_W-1:0]    r_best_idx;
    logic [trct_pkg::STAMP_W-1:0]  r_best_stamp;
    logic [31:0]                   r_best_hash;
    logic                          r_best_second;
    logic [trct_pkg::STAMP_W-1:0]  r_stamp;
    trct_pkg::t_rsp                r_res, n_res;
    logic                          r_out_valid;
    trct_pkg::t_rsp                r_out;

    logic [7:0]                    count;
    logic [trct_pkg::SECT_W-1:0]   sect, lo, e_sect;
    logic [trct_pkg::ESECT_W-1:0]  hi_raw, hi;
    logic                          sect_ok;
    logic [10:0]                   key;
    logic [31:0]                   want;
    logic                          find_hit, wipe_hit;
    logic                          free_found;
    logic [trct_pkg::IDX_W-1:0]    free_idx;
    logic [trct_pkg::IDX_W-1:0]    mem_addr;
    logic                          add_ok, hash_rewrite, is_find, is_add;
    logic                          mem_we, hash_we;
    t_entry                        new_ent;

    // Effective section count, clamped to 1..MAX_SECTIONS
    always_comb begin
        count = r_cfg;
        if (r_cfg == 8'd0) count = 8'd1;
        else if (r_cfg > 8'(trct_pkg::MAX_SECTIONS)) count = 8'(trct_pkg::MAX_SECTIONS);
    end

    assign sect    = r_req.start_address[23:trct_pkg::SECTION_BITS];
    assign sect_ok = {1'b0, sect} < {{(trct_pkg::SECT_W-7){1'b0}}, count};
    assign key     = {r_req.large_lod, r_req.aspect_code, r_req.texel_format};
    assign want    = r_req.palette_mode ? 32'd0 : r_req.content_hash;
    assign is_find = (r_req.req_type == trct_pkg::REQ_FIND);
    assign is_add  = (r_req.req_type == trct_pkg::REQ_ADD);

    // Wipe window in sections
    assign lo = (sect < trct_pkg::SECT_W'(trct_pkg::BACK_SECTIONS)) ? '0
              : sect - trct_pkg::SECT_W'(trct_pkg::BACK_SECTIONS);
    assign hi_raw = r_req.end_address[24:trct_pkg::SECTION_BITS];
    assign hi = (hi_raw >= trct_pkg::ESECT_W'(count)) ? trct_pkg::ESECT_W'(count) - 1'b1
              : hi_raw;

    // Compare against the entry read last cycle
    assign e_sect   = r_ent_q.start_a[23:trct_pkg::SECTION_BITS];
    assign find_hit = r_rd_vld && is_find && sect_ok && r_valid[r_rd_idx] &&
                      r_ent_q.start_a == r_req.start_address && r_ent_q.key == key &&
                      (want == 32'd0 || r_hash_q == want) &&
                      (!r_best_found || r_ent_q.stamp > r_best_stamp);
    assign wipe_hit = r_rd_vld && (r_req.req_type == trct_pkg::REQ_WIPE) &&
                      r_valid[r_rd_idx] &&
                      e_sect >= lo && {1'b0, e_sect} <= hi &&
                      {1'b0, r_req.start_address} < r_ent_q.end_a &&
                      {1'b0, r_ent_q.start_a} < r_req.end_address &&
                      (r_req.content_hash == 32'd0 || r_hash_q == r_req.content_hash);

    // Lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = trct_pkg::ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_found = 1'b1;
                free_idx   = trct_pkg::IDX_W'(i);
            end
        end
    end

    assign add_ok       = is_add && sect_ok && free_found;
    assign hash_rewrite = is_find && r_best_found && r_req.palette_mode &&
                          (r_best_hash != r_req.content_hash);

    // Memory port address and writes
    assign mem_addr = i_cmd.update ? (is_find ? r_best_idx : free_idx)
                                   : r_cnt[trct_pkg::IDX_W-1:0];
    assign mem_we   = i_cmd.update && add_ok;
    assign hash_we  = i_cmd.update && (add_ok || hash_rewrite);

    always_comb begin
        new_ent.start_a = r_req.start_address;
        new_ent.end_a   = r_req.end_address;
        new_ent.key     = key;
        new_ent.second  = r_req.want_second;
        new_ent.stamp   = r_stamp;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_addr] <= new_ent;
        if (hash_we) r_hash_mem[mem_addr] <= r_req.content_hash;
        r_ent_q  <= r_mem[mem_addr];
        r_hash_q <= r_hash_mem[mem_addr];
    end

    // Result of the request
    always_comb begin
        n_res = '0;
        unique case (r_req.req_type)
            trct_pkg::REQ_FIND: begin
                if (r_best_found) begin
                    n_res.tex_name = 7'({1'b0, r_best_idx} + 1'b1);
                    if (r_req.want_second && r_best_second)
                        n_res.tex2_name = 8'({2'b0, r_best_idx} + 8'(trct_pkg::ENTRIES + 1));
                    n_res.palette_changed = hash_rewrite;
                end else begin
                    n_res.status = trct_pkg::ST_NOT_FOUND;
                end
            end
            trct_pkg::REQ_ADD: begin
                if (!sect_ok) n_res.status = trct_pkg::ST_BAD_SECT;
                else if (!free_found) n_res.status = trct_pkg::ST_FULL;
                else begin
                    n_res.tex_name = 7'({1'b0, free_idx} + 1'b1);
                    if (r_req.want_second)
                        n_res.tex2_name = 8'({2'b0, free_idx} + 8'(trct_pkg::ENTRIES + 1));
                end
            end
            default: n_res = '0;
        endcase
    end

    // Request and result registers, scan read index and best-match tracking
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_req <= i_req;
        if (i_cmd.update) r_res <= n_res;
        if (find_hit) begin
            r_best_idx    <= r_rd_idx;
            r_best_stamp  <= r_ent_q.stamp;
            r_best_hash   <= r_hash_q;
            r_best_second <= r_ent_q.second;
        end
        r_rd_idx <= r_cnt[trct_pkg::IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg        <= 8'(trct_pkg::MAX_SECTIONS);
            r_valid      <= '0;
            r_cnt        <= '0;
            r_rd_vld     <= 1'b0;
            r_best_found <= 1'b0;
            r_stamp      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) r_cfg <= i_cfg_data;
            r_rd_vld <= i_cmd.scan && !r_cnt[trct_pkg::CNT_W-1];
            if (i_cmd.load) begin
                r_cnt        <= '0;
                r_best_found <= 1'b0;
            end else if (i_cmd.scan && !r_cnt[trct_pkg::CNT_W-1]) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (find_hit) r_best_found <= 1'b1;
            if (wipe_hit) r_valid[r_rd_idx] <= 1'b0;
            if (i_cmd.update && add_ok) begin
                r_valid[free_idx] <= 1'b1;
                r_stamp           <= r_stamp + 1'b1;
            end
            if (i_cmd.update && r_req.req_type == trct_pkg::REQ_CLEAR) r_valid <= '0;
            // Output register
            if (i_cmd.respond) r_out_valid <= 1'b1;
            else if (i_rsp_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.respond) r_out <= r_res;
    end

    assign o_rsp_valid      = r_out_valid;
    assign o_rsp            = r_out;
    assign o_stat.need_scan = (i_req.req_type == trct_pkg::REQ_FIND) ||
                              (i_req.req_type == trct_pkg::REQ_WIPE);
    assign o_stat.scan_done = r_cnt[trct_pkg::CNT_W-1] && !r_rd_vld;
    assign o_stat.out_free  = !r_out_valid || i_rsp_ready;

endmodule

@@ rtl/texture_region_cache_table.sv @@
// Top level: texture region cache table (controller plus datapath)
//
//  channel   signals                          payload
//  request   i_req_valid / o_req_ready        i_req (trct_pkg::t_req)
//  result    o_rsp_valid / i_rsp_ready        o_rsp (trct_pkg::t_rsp)
//  config    i_cfg_we                         i_cfg_data (section_count)
//
// Find and wipe scan all 64 entries through the one-port entry memory, then update and
// respond; add and clear skip the scan and go straight to update.
// A new request is taken the cycle after the result enters the output register, even
// while that result is still stalled; a stalled result holds the next one in its last state.
// Reset clears the valid bits at once; no clearing pass is needed.
`timescale 1ns / 1ps
module texture_region_cache_table (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  trct_pkg::t_req i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    output trct_pkg::t_rsp o_rsp,
    input  logic           i_cfg_we,
    input  logic [7:0]     i_cfg_data
);

    trct_pkg::t_cmd  cmd;
    trct_pkg::t_stat stat;

    trct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    trct_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg_data  (i_cfg_data),
        .i_cfg_we    (i_cfg_we),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

endmodule

@@ rtl/trct_checker.sv @@
// Checker: port-level properties of the texture cache table, bound to the top level
`timescale 1ns / 1ps
module trct_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_req_valid,
    input logic           o_req_ready,
    input logic           o_rsp_valid,
    input logic           i_rsp_ready,
    input trct_pkg::t_rsp o_rsp
);

    // A stalled result stays
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("result dropped or changed while stalled");

    // One request at a time
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("request taken while busy");

    // Status codes stay in range
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> o_rsp.status <= trct_pkg::ST_BAD_SECT)
        else $error("bad status code");

    // No names on failure
    a_no_name: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.status != trct_pkg::ST_OK |->
            o_rsp.tex_name == 7'd0 && o_rsp.tex2_name == 8'd0 && !o_rsp.palette_changed)
        else $error("name on a failed request");

    // Palette change only with a found entry
    a_pal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.palette_changed |-> o_rsp.tex_name != 7'd0)
        else $error("palette change without entry");

endmodule

bind texture_region_cache_table trct_checker u_trct_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_ready (o_req_ready),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_ready (i_rsp_ready),
    .o_rsp       (o_rsp)
);
